[rtl/fcm_pkg.sv]
// Shared constants, operation codes and controller/datapath interface types.
`timescale 1ns / 1ps

package fcm_pkg;

    localparam int CAPACITY_SLOTS_DEF = 32;
    localparam int VALUE_WIDTH_DEF    = 32;

    localparam int OP_W    = 2;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 6;
    localparam int OCC_W   = 6;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT    = 2'd0,
        OP_COUNT     = 2'd1,
        OP_ERASE_ONE = 2'd2,
        OP_ERASE_ALL = 2'd3
    } op_t;

    typedef struct packed {
        logic load;
        logic rd_idx;
        logic rd_next;
        logic rd_last;
        logic inc_count;
        logic mv_write;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic idx_lt_fill;
        logic nxt_lt_fill;
        logic match;
    } status_t;

endpackage

[rtl/fcm_ctrl.sv]
// Controller state machine that sequences inserts, scans and slot moves.
`timescale 1ns / 1ps

module fcm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  fcm_pkg::status_t  status,
    output fcm_pkg::cmd_t     cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_SCAN  = 5'b00100,
        S_MOVE  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                if (status.op == fcm_pkg::OP_INSERT || !status.idx_lt_fill) begin
                    state_next = S_DONE;
                end else begin
                    cmd.rd_idx = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (status.match && status.op != fcm_pkg::OP_COUNT) begin
                    // Pull the last entry down into the matching slot.
                    cmd.inc_count = 1'b1;
                    cmd.rd_last   = 1'b1;
                    state_next    = S_MOVE;
                end else begin
                    cmd.inc_count = status.match;
                    if (status.nxt_lt_fill) begin
                        cmd.rd_next = 1'b1;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_MOVE: begin
                cmd.mv_write = 1'b1;
                if (status.op == fcm_pkg::OP_ERASE_ONE) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_FETCH;
                end
            end
            S_DONE: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/fcm_datapath.sv]
// Datapath: slot memory, occupancy count, scan index, match counter and result fields.
`timescale 1ns / 1ps

module fcm_datapath #(
    parameter int CAPACITY_SLOTS = fcm_pkg::CAPACITY_SLOTS_DEF,
    parameter int VALUE_WIDTH    = fcm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [fcm_pkg::OP_W-1:0]       s_operation,
    input  logic [fcm_pkg::VALUE_W-1:0]    s_value,
    input  fcm_pkg::cmd_t                  cmd,
    output fcm_pkg::status_t               status,
    output logic [fcm_pkg::COUNT_W-1:0]    m_match_count,
    output logic                           m_found,
    output logic                           m_rejected,
    output logic [fcm_pkg::OCC_W-1:0]      m_occupancy
);

    localparam int ADDR_W = $clog2(CAPACITY_SLOTS);
    localparam int FILL_W = $clog2(CAPACITY_SLOTS + 1);

    logic [VALUE_WIDTH-1:0] slot_mem [CAPACITY_SLOTS];

    fcm_pkg::op_t           op_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic [ADDR_W-1:0]      idx_reg;
    logic [FILL_W-1:0]      count_reg;
    logic                   rejected_reg;
    logic [VALUE_WIDTH-1:0] rdata_reg;

    logic                   full;
    logic                   ins_write;
    logic [FILL_W-1:0]      idx_wide;
    logic [FILL_W-1:0]      idx_plus;
    logic [FILL_W-1:0]      fill_minus;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;

    assign full       = (fill_reg == FILL_W'(CAPACITY_SLOTS));
    assign ins_write  = cmd.load && (fcm_pkg::op_t'(s_operation) == fcm_pkg::OP_INSERT) && !full;
    assign idx_wide   = FILL_W'(idx_reg);
    assign idx_plus   = idx_wide + FILL_W'(1);
    assign fill_minus = fill_reg - FILL_W'(1);

    assign rd_en = cmd.rd_idx || cmd.rd_next || cmd.rd_last;

    always_comb begin
        priority if (cmd.rd_last) begin
            rd_addr = ADDR_W'(fill_minus);
        end else if (cmd.rd_next) begin
            rd_addr = ADDR_W'(idx_plus);
        end else begin
            rd_addr = idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        priority if (ins_write) begin
            slot_mem[ADDR_W'(fill_reg)] <= VALUE_WIDTH'(s_value);
        end else if (cmd.mv_write) begin
            slot_mem[idx_reg] <= rdata_reg;
        end
        if (rd_en) begin
            rdata_reg <= slot_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (ins_write) begin
            fill_reg <= fill_reg + FILL_W'(1);
        end else if (cmd.rd_last) begin
            fill_reg <= fill_minus;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= fcm_pkg::op_t'(s_operation);
            value_reg    <= VALUE_WIDTH'(s_value);
            idx_reg      <= '0;
            count_reg    <= '0;
            rejected_reg <= (fcm_pkg::op_t'(s_operation) == fcm_pkg::OP_INSERT) && full;
        end else begin
            if (cmd.rd_next) begin
                idx_reg <= ADDR_W'(idx_plus);
            end
            if (cmd.inc_count) begin
                count_reg <= count_reg + FILL_W'(1);
            end
        end
    end

    assign status.op          = op_reg;
    assign status.idx_lt_fill = (idx_wide < fill_reg);
    assign status.nxt_lt_fill = (idx_plus < fill_reg);
    assign status.match       = (rdata_reg == value_reg);

    assign m_match_count = fcm_pkg::COUNT_W'(count_reg);
    assign m_found       = (count_reg != '0);
    assign m_rejected    = rejected_reg;
    assign m_occupancy   = fcm_pkg::OCC_W'(fill_reg);

endmodule

[rtl/fixed_capacity_multiset.sv]
// Top level of the fixed-capacity multiset: controller and datapath joined by command and status.
`timescale 1ns / 1ps

// Each input beat carries an operation (insert, count, erase one, erase all) and a value.
// Each accepted beat produces exactly one result beat with the match count, a found flag,
// a rejected flag for an insert into a full table, and the occupancy after the operation.
// The block works on one item at a time: s_ready is high only while it is idle.
// An insert passes from idle through the fetch state to the done state, where its result is
// presented; the next input beat is taken back in idle, the state that follows the result beat.
// Count and erase with no match scan every occupied slot, reading one slot per cycle from
// the slot memory's single registered read port.
// Each entry that erase-all removes adds a move state, which moves the last entry down,
// and a fetch state that resumes the scan at the same slot.
// Erase one stops at its first match and adds a move state before its result.
// The result stays on the m_ ports while the receiver holds m_ready low; no new input is
// taken until the result beat is accepted.
// Reset empties the table by clearing the occupancy count; slot contents are not cleared
// and no clearing pass is needed, as slots at or beyond the occupancy are never read.
module fixed_capacity_multiset #(
    parameter int CAPACITY_SLOTS = fcm_pkg::CAPACITY_SLOTS_DEF,
    parameter int VALUE_WIDTH    = fcm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [fcm_pkg::OP_W-1:0]       s_operation,
    input  logic [fcm_pkg::VALUE_W-1:0]    s_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [fcm_pkg::COUNT_W-1:0]    m_match_count,
    output logic                           m_found,
    output logic                           m_rejected,
    output logic [fcm_pkg::OCC_W-1:0]      m_occupancy
);

    fcm_pkg::cmd_t    cmd;
    fcm_pkg::status_t status;

    fcm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fcm_datapath #(
        .CAPACITY_SLOTS (CAPACITY_SLOTS),
        .VALUE_WIDTH    (VALUE_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_operation   (s_operation),
        .s_value       (s_value),
        .cmd           (cmd),
        .status        (status),
        .m_match_count (m_match_count),
        .m_found       (m_found),
        .m_rejected    (m_rejected),
        .m_occupancy   (m_occupancy)
    );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the fixed-capacity multiset: shadow-table prediction and random traffic.
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic [fcm_pkg::COUNT_W-1:0] match_count;
        logic                        found;
        logic                        rejected;
        logic [fcm_pkg::OCC_W-1:0]   occupancy;
    } bag_reply_t;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_OVERFLOW} episode_t;

    class multiset_tracker;
        logic [fcm_pkg::VALUE_W-1:0] shadow_slots [fcm_pkg::CAPACITY_SLOTS_DEF];
        int                          shadow_fill;
        bag_reply_t                  expected_replies [$];
        int                          mismatches;

        function new();
            shadow_fill = 0;
            mismatches  = 0;
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 100) begin
                $display("ERROR at %0t: %s", $realtime, msg);
            end
            mismatches++;
        endtask

        function void note_request(fcm_pkg::op_t op, logic [fcm_pkg::VALUE_W-1:0] v);
            bag_reply_t r;
            int         i;
            int         hits;
            bit         done;
            r.match_count = '0;
            r.found       = 1'b0;
            r.rejected    = 1'b0;
            hits          = 0;
            done          = 0;
            case (op)
                fcm_pkg::OP_INSERT: begin
                    if (shadow_fill >= fcm_pkg::CAPACITY_SLOTS_DEF) begin
                        r.rejected = 1'b1;
                    end else begin
                        shadow_slots[shadow_fill] = v;
                        shadow_fill++;
                    end
                end
                fcm_pkg::OP_COUNT: begin
                    for (i = 0; i < shadow_fill; i++) begin
                        if (shadow_slots[i] == v) begin
                            hits++;
                        end
                    end
                end
                fcm_pkg::OP_ERASE_ONE: begin
                    for (i = 0; i < shadow_fill && !done; i++) begin
                        if (shadow_slots[i] == v) begin
                            shadow_fill--;
                            shadow_slots[i] = shadow_slots[shadow_fill];
                            hits = 1;
                            done = 1;
                        end
                    end
                end
                fcm_pkg::OP_ERASE_ALL: begin
                    i = 0;
                    while (i < shadow_fill) begin
                        if (shadow_slots[i] == v) begin
                            shadow_fill--;
                            shadow_slots[i] = shadow_slots[shadow_fill];
                            hits++;
                        end else begin
                            i++;
                        end
                    end
                end
            endcase
            r.match_count = hits[fcm_pkg::COUNT_W-1:0];
            r.found       = (hits != 0);
            r.occupancy   = shadow_fill[fcm_pkg::OCC_W-1:0];
            expected_replies.push_back(r);
        endfunction

        task check_response(bag_reply_t got);
            bag_reply_t want;
            if (expected_replies.size() == 0) begin
                report_mismatch("result beat with no request pending");
            end else begin
                want = expected_replies.pop_front();
                if (got.match_count !== want.match_count) begin
                    report_mismatch($sformatf("match_count %0d, want %0d",
                                              got.match_count, want.match_count));
                end
                if (got.found !== want.found) begin
                    report_mismatch($sformatf("found %b, want %b", got.found, want.found));
                end
                if (got.rejected !== want.rejected) begin
                    report_mismatch($sformatf("rejected %b, want %b",
                                              got.rejected, want.rejected));
                end
                if (got.occupancy !== want.occupancy) begin
                    report_mismatch($sformatf("occupancy %0d, want %0d",
                                              got.occupancy, want.occupancy));
                end
            end
        endtask
    endclass

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic [fcm_pkg::OP_W-1:0]    s_operation;
    logic [fcm_pkg::VALUE_W-1:0] s_value;
    logic                        m_valid;
    logic                        m_ready;
    logic [fcm_pkg::COUNT_W-1:0] m_match_count;
    logic                        m_found;
    logic                        m_rejected;
    logic [fcm_pkg::OCC_W-1:0]   m_occupancy;

    multiset_tracker             tracker = new();
    bit                          idle_on;
    int                          beats_sent;
    logic [fcm_pkg::VALUE_W-1:0] value_pool [6];

    fixed_capacity_multiset dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_match_count (m_match_count),
        .m_found       (m_found),
        .m_rejected    (m_rejected),
        .m_occupancy   (m_occupancy)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic drive_item(fcm_pkg::op_t op, logic [fcm_pkg::VALUE_W-1:0] v);
        @(negedge aclk);
        while (idle_on && $urandom_range(0, 99) < 14) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_value     <= v;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        tracker.note_request(op, v);
        beats_sent++;
    endtask

    task automatic refresh_pool();
        int k;
        int r;
        for (k = 0; k < 6; k++) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                value_pool[k] = '0;
            end else if (r == 1) begin
                value_pool[k] = '1;
            end else begin
                value_pool[k] = $urandom;
            end
        end
    endtask

    function automatic logic [fcm_pkg::VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 80) begin
            return value_pool[$urandom_range(0, 5)];
        end
        return $urandom;
    endfunction

    function automatic fcm_pkg::op_t pick_op(episode_t mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                if (r < 65) return fcm_pkg::OP_INSERT;
                if (r < 80) return fcm_pkg::OP_COUNT;
                if (r < 90) return fcm_pkg::OP_ERASE_ONE;
                return fcm_pkg::OP_ERASE_ALL;
            end
            MODE_DRAIN: begin
                if (r < 20) return fcm_pkg::OP_INSERT;
                if (r < 40) return fcm_pkg::OP_COUNT;
                if (r < 75) return fcm_pkg::OP_ERASE_ONE;
                return fcm_pkg::OP_ERASE_ALL;
            end
            default: begin
                return fcm_pkg::op_t'(r[1:0]);
            end
        endcase
    endfunction

    initial begin
        episode_t mode;
        int       len;
        int       k;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_operation = '0;
        s_value     = '0;
        idle_on     = 1'b1;
        beats_sent  = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Operations on an empty table, then inserts with repeated values and counts.
        drive_item(fcm_pkg::OP_COUNT, '0);
        drive_item(fcm_pkg::OP_ERASE_ONE, '0);
        drive_item(fcm_pkg::OP_ERASE_ALL, '1);
        drive_item(fcm_pkg::OP_INSERT, '0);
        drive_item(fcm_pkg::OP_INSERT, '1);
        drive_item(fcm_pkg::OP_INSERT, '0);
        drive_item(fcm_pkg::OP_INSERT, 32'hA5A5_5A5A);
        drive_item(fcm_pkg::OP_COUNT, '0);
        drive_item(fcm_pkg::OP_COUNT, '1);
        drive_item(fcm_pkg::OP_COUNT, 32'h1234_5678);
        // Erase one with no match leaves the table alone; erases of matching values follow.
        drive_item(fcm_pkg::OP_ERASE_ONE, 32'h1234_5678);
        drive_item(fcm_pkg::OP_ERASE_ONE, '0);
        drive_item(fcm_pkg::OP_COUNT, '0);
        drive_item(fcm_pkg::OP_ERASE_ALL, '0);
        drive_item(fcm_pkg::OP_ERASE_ALL, '1);
        drive_item(fcm_pkg::OP_ERASE_ALL, 32'hA5A5_5A5A);
        drive_item(fcm_pkg::OP_INSERT, 32'd7);
        drive_item(fcm_pkg::OP_INSERT, 32'd7);
        drive_item(fcm_pkg::OP_INSERT, 32'd7);
        drive_item(fcm_pkg::OP_INSERT, 32'd8);
        drive_item(fcm_pkg::OP_ERASE_ALL, 32'd7);
        drive_item(fcm_pkg::OP_COUNT, 32'd8);
        drive_item(fcm_pkg::OP_ERASE_ONE, 32'd8);

        while (beats_sent < 1110) begin
            refresh_pool();
            mode = episode_t'($urandom_range(0, 3));
            len  = $urandom_range(20, 80);
            if (mode == MODE_OVERFLOW) begin
                // Fill past capacity so that several inserts are refused.
                for (k = 0; k < 36; k++) begin
                    idle_on = !(beats_sent >= 450 && beats_sent < 700);
                    drive_item(fcm_pkg::OP_INSERT, pick_value());
                end
                len = $urandom_range(5, 15);
            end
            for (k = 0; k < len; k++) begin
                idle_on = !(beats_sent >= 450 && beats_sent < 700);
                drive_item(pick_op(mode), pick_value());
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        idle_on = 1'b1;
        while (tracker.expected_replies.size() != 0) begin
            @(posedge aclk);
        end
        repeat (120) @(posedge aclk);
        if (tracker.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= !(idle_on && $urandom_range(0, 99) < 14);
        end
    end

    always @(posedge aclk) begin
        bag_reply_t got;
        if (aresetn && m_valid && m_ready) begin
            got.match_count = m_match_count;
            got.found       = m_found;
            got.rejected    = m_rejected;
            got.occupancy   = m_occupancy;
            tracker.check_response(got);
        end
    end

endmodule
